[hw/rtl/bpa_pkg.sv]
package bpa_pkg;

  localparam int PAGE_W   = 15;
  localparam int STATUS_W = 2;
  localparam int RSV_W    = 11;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // word select within the register window (paddr bit 2)
  localparam logic REG_RESERVED_WORDS = 1'b0;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } bpa_req_type_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_NOMEM  = 2'd1,
    STS_BADIDX = 2'd2
  } bpa_status_e;

  typedef struct packed {
    bpa_req_type_e     req_type;
    logic [PAGE_W-1:0] page_index;
  } bpa_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] granted_page;
    bpa_status_e       status;
  } bpa_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_CHK,
    ST_FWR
  } bpa_state_e;

endpackage

[hw/rtl/bitmap_page_allocator.sv]
// Channel  | Handshake                 | Payload
// request  | start_i, busy_o           | req_i    (req_type, page_index)
// result   | done_o (one-cycle strobe) | res_o    (granted_page, status)
// config   | APB psel/penable/pwrite   | paddr_i, pwdata_i, prdata_o
//
// After reset the bitmap is zeroed by a clearing pass over all BITMAP_WORDS words; busy_o
// stays high for that time. Config transfers are taken throughout.
// Allocate: one bitmap word read per cycle from the memory's single read port; the
// first word with a clear bit, searched upward from the reserved words, gives the
// granted page, and STS_NOMEM returns when none is found. Free: clears the page's bit,
// or returns STS_BADIDX for an index outside the usable region.
// One request at a time; the result strobe cannot be stalled by the receiver.
module bitmap_page_allocator #(
  parameter int BITMAP_WORDS  = 1024,
  parameter int BITS_PER_WORD = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  bpa_pkg::bpa_req_t           req_i,
  output logic                        done_o,
  output bpa_pkg::bpa_res_t           res_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [bpa_pkg::APB_AW-1:0]  paddr_i,
  input  logic [bpa_pkg::APB_DW-1:0]  pwdata_i,
  output logic [bpa_pkg::APB_DW-1:0]  prdata_o,
  output logic                        pready_o
);

  import bpa_pkg::*;

  localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

  logic [RSV_W-1:0]         reserved_q;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic [BITS_PER_WORD-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic [BITS_PER_WORD-1:0] mem_rdata;

  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_RESERVED_WORDS)) begin
      reserved_q <= pwdata_i[RSV_W-1:0];
    end
  end

  assign prdata_o = (paddr_i[2] == REG_RESERVED_WORDS) ? APB_DW'(reserved_q) : '0;

  bpa_ctrl #(
    .WORDS (BITMAP_WORDS),
    .BPW   (BITS_PER_WORD),
    .AW    (AW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .req_i            (req_i),
    .reserved_words_i (reserved_q),
    .busy_o           (busy_o),
    .done_o           (done_o),
    .res_o            (res_o),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  bpa_mem #(
    .DEPTH (BITMAP_WORDS),
    .WIDTH (BITS_PER_WORD),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[hw/rtl/bpa_mem.sv]
module bpa_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = 10
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bpa_ctrl.sv]
module bpa_ctrl #(
  parameter int WORDS = 1024,
  parameter int BPW   = 32,
  parameter int AW    = 10
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  bpa_pkg::bpa_req_t       req_i,
  input  logic [bpa_pkg::RSV_W-1:0] reserved_words_i,
  output logic                    busy_o,
  output logic                    done_o,
  output bpa_pkg::bpa_res_t       res_o,
  output logic                    mem_we_o,
  output logic [AW-1:0]           mem_waddr_o,
  output logic [BPW-1:0]          mem_wdata_o,
  output logic                    mem_re_o,
  output logic [AW-1:0]           mem_raddr_o,
  input  logic [BPW-1:0]          mem_rdata_i
);

  import bpa_pkg::*;

  localparam int BIT_W = $clog2(BPW);
  localparam int CW    = $clog2(WORDS + 1);
  localparam int RW    = (CW > RSV_W) ? CW : RSV_W;
  // idx / BPW as (idx * DIV_M) >> DIV_S, exact for every 15-bit idx
  localparam int DIV_S = PAGE_W + BIT_W;
  localparam int unsigned DIV_M = ((32'd1 << DIV_S) + BPW - 1) / BPW;
  localparam int MW    = PAGE_W + 2;
  localparam int PRW   = PAGE_W + MW;
  localparam int QW    = PRW - DIV_S;
  localparam int XW    = (RW > QW) ? RW : QW;
  localparam int PCW   = (AW + BIT_W + 1 > PAGE_W) ? AW + BIT_W + 1 : PAGE_W;
  localparam logic [BPW-1:0] FULL = {BPW{1'b1}};

  bpa_state_e        state_q, state_d;
  logic [RW-1:0]     scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     chk_q, chk_d;
  logic [PAGE_W-1:0] idx_q, idx_d;
  logic [PRW-1:0]    prod_q, prod_d;
  logic [AW-1:0]     fw_q, fw_d;
  logic [BIT_W-1:0]  fb_q, fb_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              done_q, done_d;
  bpa_res_t          res_q, res_d;

  logic              issue;
  logic              word_full;
  logic [BIT_W-1:0]  zbit;
  logic [PCW-1:0]    page_full;
  logic [QW-1:0]     quot;
  logic [PAGE_W-1:0] rem;
  logic              bad_idx;

  assign issue     = (state_q == ST_SCAN) && (scan_q < RW'(WORDS));
  assign word_full = (mem_rdata_i == FULL);

  // lowest clear bit of the word just read
  always_comb begin
    zbit = '0;
    for (int i = BPW - 1; i >= 0; i--) begin
      if (!mem_rdata_i[i]) zbit = BIT_W'(i);
    end
  end

  assign page_full = PCW'(chk_q) * PCW'(BPW) + PCW'(zbit);

  assign quot    = prod_q[PRW-1:DIV_S];
  assign rem     = idx_q - PAGE_W'(PRW'(quot) * PRW'(BPW));
  assign bad_idx = (XW'(quot) < XW'(reserved_words_i)) || (XW'(quot) >= XW'(WORDS));

  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    pend_d      = pend_q;
    chk_d       = chk_q;
    idx_d       = idx_q;
    prod_d      = prod_q;
    fw_d        = fw_q;
    fb_d        = fb_q;
    clr_d       = clr_q;
    done_d      = 1'b0;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        if (clr_q == AW'(WORDS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          if (req_i.req_type == REQ_ALLOC) begin
            scan_d  = RW'(reserved_words_i);
            pend_d  = 1'b0;
            state_d = ST_SCAN;
          end else begin
            idx_d   = req_i.page_index;
            state_d = ST_DIV;
          end
        end
      end
      ST_SCAN: begin
        // one read issued per cycle, word checked in the cycle after
        mem_re_o    = issue;
        mem_raddr_o = scan_q[AW-1:0];
        pend_d      = issue;
        if (issue) begin
          scan_d = scan_q + 1'b1;
          chk_d  = scan_q[AW-1:0];
        end
        if (pend_q && !word_full) begin
          mem_we_o           = 1'b1;
          mem_waddr_o        = chk_q;
          mem_wdata_o        = mem_rdata_i | (mem_rdata_i + 1'b1);
          done_d             = 1'b1;
          res_d.granted_page = page_full[PAGE_W-1:0];
          res_d.status       = STS_OK;
          state_d            = ST_IDLE;
        end else if (!issue && !pend_q) begin
          done_d             = 1'b1;
          res_d.granted_page = '0;
          res_d.status       = STS_NOMEM;
          state_d            = ST_IDLE;
        end
      end
      ST_DIV: begin
        prod_d  = PRW'(idx_q) * PRW'(DIV_M);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (bad_idx) begin
          done_d             = 1'b1;
          res_d.granted_page = '0;
          res_d.status       = STS_BADIDX;
          state_d            = ST_IDLE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = AW'(XW'(quot));
          fw_d        = AW'(XW'(quot));
          fb_d        = rem[BIT_W-1:0];
          state_d     = ST_FWR;
        end
      end
      ST_FWR: begin
        mem_we_o           = 1'b1;
        mem_waddr_o        = fw_q;
        mem_wdata_o        = mem_rdata_i & ~(BPW'(1) << fb_q);
        done_d             = 1'b1;
        res_d.granted_page = '0;
        res_d.status       = STS_OK;
        state_d            = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    chk_q  <= chk_d;
    idx_q  <= idx_d;
    prod_q <= prod_d;
    fw_q   <= fw_d;
    fb_q   <= fb_d;
    res_q  <= res_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
